// ----- rtl/ufcef_pkg.sv -----
// Package for the union-find cycle edge filter.
// Holds widths, the forest entry layout and the engine command struct.
// No dependencies; used by ufcef_engine and union_find_cycle_edge_filter.
package ufcef_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VERT_BITS    = 10;
  localparam int CNT_BITS     = 11;
  localparam int RANK_BITS    = 4;
  localparam int WEIGHT_BITS  = 16;
  localparam int TDATA_BITS   = 40;

  localparam logic [RANK_BITS-1:0] RANK_MAX   = 4'd15;
  localparam logic [CNT_BITS-1:0]  CNT_RESET  = 11'd1024;
  localparam logic [CNT_BITS-1:0]  CNT_LIMIT  = 11'd1024;
  localparam logic [VERT_BITS-1:0] LAST_VERT  = 10'd1023;

  typedef logic [VERT_BITS-1:0] vert_t;

  // One forest entry: parent pointer and rank, kept in one memory word.
  typedef struct packed {
    logic [RANK_BITS-1:0] rank;
    vert_t                parent;
  } node_t;

  // Work handed to the engine for one edge.
  typedef struct packed {
    logic  clear;   // reset the forest to singletons first
    logic  check;   // endpoints in range: run the finds and the union
    vert_t u;
    vert_t v;
  } cmd_t;

endpackage

// ----- rtl/union_find_cycle_edge_filter.sv -----
// Top level of the union-find cycle edge filter: stream ports, count register,
// output register. Depends on ufcef_pkg and ufcef_engine.
//
// Usage: edges arrive on the slave stream sorted by descending weight. Each
// transfer carries one edge; the block answers with exactly one transfer on
// the master stream that echoes the edge and says whether it closes a cycle
// (edge_removed) or whether an endpoint lies at or above the vertex count
// (index_error). Edges with an index error leave the forest untouched, and
// start_graph returns every vertex to a singleton set before its edge.
//
// Timing: once an edge is accepted, the engine walks each endpoint's chain to
// its root a node at a time, points each node on the walk at the root (path
// compression) and joins the two roots, with an extra rank update when equal
// ranks are joined. No new edge is taken until the result has left the engine.
// The single forest memory, one read and one write a cycle, sets this pace. A
// clearing pass rewrites all 1024 forest entries after reset and on every
// start_graph edge; no edge is taken during it, but cfg_we writes are. The
// result sits in an output register; when the receiver stalls the next edge
// may still be accepted and processed, and the engine then waits with its
// result until the output register frees up.
module union_find_cycle_edge_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ufcef_pkg::CNT_BITS-1:0]      cfg_wdata,   // vertex_count
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [9:0] from_vertex, [19:10] to_vertex, [35:20] edge_weight, [39:36] zero
  input  logic [ufcef_pkg::TDATA_BITS-1:0]    s_axis_tdata,
  // [0] start_graph
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [9:0] out_from, [19:10] out_to, [35:20] out_weight, [39:36] zero
  output logic [ufcef_pkg::TDATA_BITS-1:0]    m_axis_tdata,
  // [0] edge_removed, [1] index_error
  output logic [1:0]                          m_axis_tuser
);

  logic [ufcef_pkg::CNT_BITS-1:0]    vertex_count;
  logic [ufcef_pkg::CNT_BITS-1:0]    cnt_eff;
  ufcef_pkg::vert_t                  in_u;
  ufcef_pkg::vert_t                  in_v;
  logic [ufcef_pkg::WEIGHT_BITS-1:0] in_w;
  logic                              in_err;
  logic                              accept;
  ufcef_pkg::cmd_t                   cmd;

  // Echo fields held while the engine works on the edge.
  ufcef_pkg::vert_t                  hold_u;
  ufcef_pkg::vert_t                  hold_v;
  logic [ufcef_pkg::WEIGHT_BITS-1:0] hold_w;
  logic                              hold_err;

  logic                              eng_ready;
  logic                              res_valid;
  logic                              res_ready;
  logic                              res_removed;
  logic                              res_take;

  assign in_u = s_axis_tdata[ufcef_pkg::VERT_BITS-1:0];
  assign in_v = s_axis_tdata[2*ufcef_pkg::VERT_BITS-1:ufcef_pkg::VERT_BITS];
  assign in_w = s_axis_tdata[2*ufcef_pkg::VERT_BITS+ufcef_pkg::WEIGHT_BITS-1:
                             2*ufcef_pkg::VERT_BITS];

  // Counts above the forest size are capped; a count of zero flags every edge.
  assign cnt_eff = (vertex_count > ufcef_pkg::CNT_LIMIT) ? ufcef_pkg::CNT_LIMIT
                                                         : vertex_count;
  assign in_err  = ({1'b0, in_u} >= cnt_eff) || ({1'b0, in_v} >= cnt_eff);

  assign s_axis_tready = eng_ready;
  assign accept        = s_axis_tvalid && eng_ready;

  assign cmd = '{clear: s_axis_tuser, check: !in_err, u: in_u, v: in_v};

  assign res_ready = !m_axis_tvalid || m_axis_tready;
  assign res_take  = res_valid && res_ready;

  ufcef_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .go         (accept),
    .cmd_in     (cmd),
    .ready      (eng_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_removed(res_removed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= ufcef_pkg::CNT_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_u   <= in_u;
      hold_v   <= in_v;
      hold_w   <= in_w;
      hold_err <= in_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_axis_tdata <= {{(ufcef_pkg::TDATA_BITS - 2*ufcef_pkg::VERT_BITS
                         - ufcef_pkg::WEIGHT_BITS){1'b0}},
                       hold_w, hold_v, hold_u};
      m_axis_tuser <= {hold_err, res_removed};
    end
  end

endmodule

// ----- rtl/ufcef_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ufcef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ufcef_engine.sv -----
// Union-find engine: clearing pass, find with path compression, union by rank.
// Depends on ufcef_pkg and ufcef_ram (the parent/rank forest memory).
module ufcef_engine (
  input  logic           clk,
  input  logic           rst,
  input  logic           go,
  input  ufcef_pkg::cmd_t cmd_in,
  output logic           ready,
  output logic           res_valid,
  input  logic           res_ready,
  output logic           res_removed
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WSTART = 4'd2;
  localparam logic [3:0] S_WALK   = 4'd3;
  localparam logic [3:0] S_CSTART = 4'd4;
  localparam logic [3:0] S_COMP   = 4'd5;
  localparam logic [3:0] S_UNION  = 4'd6;
  localparam logic [3:0] S_BUMP   = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]                       state;
  ufcef_pkg::vert_t                 clr_addr;
  logic                             item_pend;
  logic                             check;
  logic                             phase;
  ufcef_pkg::vert_t                 v_hold;
  ufcef_pkg::vert_t                 x;
  ufcef_pkg::vert_t                 node;
  ufcef_pkg::vert_t                 root;
  logic [ufcef_pkg::RANK_BITS-1:0]  root_rank;
  ufcef_pkg::vert_t                 ru;
  logic [ufcef_pkg::RANK_BITS-1:0]  rank_u;
  logic                             removed;

  logic                             we;
  ufcef_pkg::vert_t                 waddr;
  ufcef_pkg::node_t                 wdata;
  ufcef_pkg::vert_t                 raddr;
  logic [$bits(ufcef_pkg::node_t)-1:0] rdata_raw;
  ufcef_pkg::node_t                 rd;

  assign rd = ufcef_pkg::node_t'(rdata_raw);

  ufcef_ram #(
    .WIDTH($bits(ufcef_pkg::node_t)),
    .DEPTH(ufcef_pkg::MAX_VERTICES)
  ) u_forest (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata_raw)
  );

  assign ready       = (state == S_IDLE);
  assign res_valid   = (state == S_DONE);
  assign res_removed = removed;

  // Memory port control. The read address follows the walk so that each
  // cycle examines one node of the chain.
  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '{rank: '0, parent: clr_addr};
    raddr = node;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_WSTART: begin
        raddr = x;
      end
      S_WALK: begin
        raddr = rd.parent;
      end
      S_CSTART: begin
        raddr = x;
      end
      S_COMP: begin
        we    = 1'b1;
        waddr = node;
        wdata = '{rank: rd.rank, parent: root};
        raddr = rd.parent;
      end
      S_UNION: begin
        we = (ru != root);
        if (rank_u < root_rank) begin
          waddr = ru;
          wdata = '{rank: rank_u, parent: root};
        end else begin
          waddr = root;
          wdata = '{rank: root_rank, parent: ru};
        end
      end
      S_BUMP: begin
        we    = 1'b1;
        waddr = ru;
        wdata = '{rank: ufcef_pkg::RANK_BITS'(rank_u + 1'b1), parent: ru};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      item_pend <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ufcef_pkg::LAST_VERT) begin
            if (!item_pend) begin
              state <= S_IDLE;
            end else if (check) begin
              state <= S_WSTART;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_IDLE: begin
          if (go) begin
            item_pend <= 1'b1;
            check     <= cmd_in.check;
            x         <= cmd_in.u;
            v_hold    <= cmd_in.v;
            phase     <= 1'b0;
            removed   <= 1'b0;
            clr_addr  <= '0;
            if (cmd_in.clear) begin
              state <= S_CLEAR;
            end else if (cmd_in.check) begin
              state <= S_WSTART;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WSTART: begin
          node  <= x;
          state <= S_WALK;
        end
        S_WALK: begin
          if (rd.parent == node) begin
            root      <= node;
            root_rank <= rd.rank;
            state     <= S_CSTART;
          end else begin
            node <= rd.parent;
          end
        end
        S_CSTART, S_COMP: begin
          if ((state == S_CSTART && x == root) ||
              (state == S_COMP && rd.parent == root)) begin
            // This find is complete.
            if (!phase) begin
              ru     <= root;
              rank_u <= root_rank;
              x      <= v_hold;
              phase  <= 1'b1;
              state  <= S_WSTART;
            end else begin
              state <= S_UNION;
            end
          end else begin
            node  <= (state == S_CSTART) ? x : rd.parent;
            state <= S_COMP;
          end
        end
        S_UNION: begin
          if (ru == root) begin
            removed <= 1'b1;
            state   <= S_DONE;
          end else if (rank_u == root_rank && rank_u != ufcef_pkg::RANK_MAX) begin
            state <= S_BUMP;
          end else begin
            state <= S_DONE;
          end
        end
        S_BUMP: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            item_pend <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/union_find_cycle_edge_filter_test.sv -----
// Self-checking testbench for union_find_cycle_edge_filter: streams edges, predicts each
// verdict with its own union-find forest and checks every result transfer in order.
// Depends on ufcef_pkg and the union_find_cycle_edge_filter RTL.
`timescale 1ns / 1ps

module union_find_cycle_edge_filter_test;

  // One edge as it travels on the slave stream.
  typedef struct packed {
    logic                              start;
    ufcef_pkg::vert_t                  from_v;
    ufcef_pkg::vert_t                  to_v;
    logic [ufcef_pkg::WEIGHT_BITS-1:0] weight;
  } edge_item_t;

  // The verdict the block should return for one edge.
  typedef struct packed {
    logic                              removed;
    logic                              index_error;
    ufcef_pkg::vert_t                  from_v;
    ufcef_pkg::vert_t                  to_v;
    logic [ufcef_pkg::WEIGHT_BITS-1:0] weight;
  } edge_verdict_t;

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [ufcef_pkg::CNT_BITS-1:0]   cfg_wdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // [9:0] from_vertex, [19:10] to_vertex, [35:20] edge_weight, [39:36] zero
  logic [ufcef_pkg::TDATA_BITS-1:0] s_axis_tdata = '0;
  // [0] start_graph
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // [9:0] out_from, [19:10] out_to, [35:20] out_weight, [39:36] zero
  logic [ufcef_pkg::TDATA_BITS-1:0] m_axis_tdata;
  // [0] edge_removed, [1] index_error
  logic [1:0]                       m_axis_tuser;

  union_find_cycle_edge_filter uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow forest, updated on each accepted edge, and count register, written like the block's.
  ufcef_pkg::vert_t                forest_parent [ufcef_pkg::MAX_VERTICES];
  logic [ufcef_pkg::RANK_BITS-1:0] forest_rank   [ufcef_pkg::MAX_VERTICES];
  logic [ufcef_pkg::CNT_BITS-1:0]  model_count;

  edge_item_t    pending_edges[$];
  edge_verdict_t expected_verdicts[$];

  int unsigned fail_count = 0;
  int unsigned accepted_edges = 0;
  logic        in_fire = 1'b0;     // slave transfer seen at the last rising edge
  int          send_gap = 0;
  int          ready_gap = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  logic        calm = 1'b0;        // no idling on either side once set

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every vertex back into a set of its own.
  function automatic void clear_forest();
    for (int i = 0; i < ufcef_pkg::MAX_VERTICES; i++) begin
      forest_parent[i] = ufcef_pkg::vert_t'(i);
      forest_rank[i]   = '0;
    end
  endfunction

  // Root of x; every node on the walk is then pointed straight at that root.
  function automatic ufcef_pkg::vert_t find_root(input ufcef_pkg::vert_t x);
    ufcef_pkg::vert_t root;
    ufcef_pkg::vert_t cur;
    ufcef_pkg::vert_t nxt;
    int               steps;
    root  = x;
    steps = 0;
    while (forest_parent[root] != root && steps < ufcef_pkg::MAX_VERTICES) begin
      root = forest_parent[root];
      steps++;
    end
    cur   = x;
    steps = 0;
    while (cur != root && steps < ufcef_pkg::MAX_VERTICES) begin
      nxt                = forest_parent[cur];
      forest_parent[cur] = root;
      cur                = nxt;
      steps++;
    end
    return root;
  endfunction

  // Runs one edge through the shadow forest and returns the verdict the block owes us.
  function automatic edge_verdict_t judge_edge(input logic [ufcef_pkg::TDATA_BITS-1:0] data,
                                               input logic start);
    edge_verdict_t    verdict;
    ufcef_pkg::vert_t u;
    ufcef_pkg::vert_t v;
    ufcef_pkg::vert_t ru;
    ufcef_pkg::vert_t rv;
    int unsigned      limit;
    u     = data[ufcef_pkg::VERT_BITS-1:0];
    v     = data[2*ufcef_pkg::VERT_BITS-1:ufcef_pkg::VERT_BITS];
    // Counts above the forest size act as the full forest.
    limit = (model_count > ufcef_pkg::CNT_LIMIT) ? int'(ufcef_pkg::CNT_LIMIT)
                                                 : int'(model_count);
    if (start)
      clear_forest();
    verdict.removed     = 1'b0;
    verdict.index_error = 1'b0;
    verdict.from_v      = u;
    verdict.to_v        = v;
    verdict.weight      = data[2*ufcef_pkg::VERT_BITS+ufcef_pkg::WEIGHT_BITS-1:
                               2*ufcef_pkg::VERT_BITS];
    if (u >= limit || v >= limit) begin
      // Out-of-range endpoint: flagged, forest untouched (the clear above still stands).
      verdict.index_error = 1'b1;
    end else begin
      ru = find_root(u);
      rv = find_root(v);
      if (ru == rv) begin
        // Same set already, which also covers a self loop.
        verdict.removed = 1'b1;
      end else if (forest_rank[ru] < forest_rank[rv]) begin
        forest_parent[ru] = rv;
      end else begin
        forest_parent[rv] = ru;
        if (forest_rank[ru] == forest_rank[rv] && forest_rank[ru] < ufcef_pkg::RANK_MAX)
          forest_rank[ru] = forest_rank[ru] + 1'b1;
      end
    end
    return verdict;
  endfunction

  // Shadow state follows reset, register writes and every accepted slave transfer.
  always @(posedge clk) begin
    edge_verdict_t verdict_now;
    if (rst) begin
      model_count = ufcef_pkg::CNT_RESET;
      clear_forest();
      in_fire <= 1'b0;
    end else begin
      if (cfg_we)
        model_count = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        verdict_now       = judge_edge(s_axis_tdata, s_axis_tuser);
        expected_verdicts = {expected_verdicts, verdict_now};
        accepted_edges++;
      end
      in_fire <= s_axis_tvalid && s_axis_tready;
    end
  end

  // Driver: presents the next pending edge once the current one has gone, with random gaps.
  always @(negedge clk) begin
    edge_item_t e;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (send_gap > 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_edges.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap      <= $urandom_range(0, 3);
        s_axis_tvalid <= 1'b0;
      end else begin
        e = pending_edges.pop_front();
        s_axis_tdata  <= {4'b0000, e.weight, e.to_v, e.from_v};
        s_axis_tuser  <= e.start;
        s_axis_tvalid <= 1'b1;
      end
    end
  end

  // Receiver readiness. One long hold-off early in the random part lets the block back up
  // into its input; otherwise the receiver stalls in short random bursts.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && accepted_edges >= 100) begin
      hold_done     <= 1'b1;
      hold_left     <= 300;
      m_axis_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap     <= ready_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      ready_gap     <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checker: each master transfer against the oldest outstanding verdict.
  always @(posedge clk) begin : check_results
    edge_verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_verdicts.size() == 0) begin
        $error("result transfer with no edge outstanding: tdata=%h tuser=%b",
               m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (m_axis_tuser[0] !== want.removed) begin
          $error("edge_removed expected %0d got %0d", want.removed, m_axis_tuser[0]);
          fail_count++;
        end
        if (m_axis_tuser[1] !== want.index_error) begin
          $error("index_error expected %0d got %0d", want.index_error, m_axis_tuser[1]);
          fail_count++;
        end
        if (m_axis_tdata[9:0] !== want.from_v) begin
          $error("out_from expected %0d got %0d", want.from_v, m_axis_tdata[9:0]);
          fail_count++;
        end
        if (m_axis_tdata[19:10] !== want.to_v) begin
          $error("out_to expected %0d got %0d", want.to_v, m_axis_tdata[19:10]);
          fail_count++;
        end
        if (m_axis_tdata[35:20] !== want.weight) begin
          $error("out_weight expected %0d got %0d", $signed(want.weight),
                 $signed(m_axis_tdata[35:20]));
          fail_count++;
        end
        if (m_axis_tdata[39:36] !== 4'b0000) begin
          $error("tdata pad expected 0 got %h", m_axis_tdata[39:36]);
          fail_count++;
        end
      end
    end
  end

  task automatic push_edge(input logic start, input int unsigned from_v,
                           input int unsigned to_v, input int weight);
    edge_item_t e;
    e.start       = start;
    e.from_v      = ufcef_pkg::vert_t'(from_v);
    e.to_v        = ufcef_pkg::vert_t'(to_v);
    e.weight      = weight[ufcef_pkg::WEIGHT_BITS-1:0];
    pending_edges = {pending_edges, e};
  endtask

  // The count register may only change while nothing is in flight. The state is looked at
  // on rising edges, where the driver leaves it alone.
  task automatic drain_edges();
    while (pending_edges.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_vertex_count(input int unsigned value);
    drain_edges();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[ufcef_pkg::CNT_BITS-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random edges for one count setting. Most come in graph runs: a start on the first edge,
  // endpoints in range (often packed into a few dozen vertices so cycles are common) and
  // weights falling. About one in ten is noise with arbitrary fields.
  task automatic queue_random_edges(input int unsigned count, input int unsigned n);
    int unsigned eff;
    int unsigned span;
    int unsigned made;
    int unsigned run_left;
    logic        start;
    int          wgt;
    eff      = (count > ufcef_pkg::MAX_VERTICES) ? ufcef_pkg::MAX_VERTICES : count;
    made     = 0;
    run_left = 0;
    start    = 1'b0;
    wgt      = 0;
    while (made < n) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 60);
        // The first run sometimes opens without a start, so links from before stay live.
        start    = (made > 0) || ($urandom_range(0, 3) != 0);
        wgt      = int'($urandom_range(0, 65535)) - 32768;
      end
      if (eff == 0 || $urandom_range(0, 9) == 0) begin
        push_edge(start | ($urandom_range(0, 15) == 0), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), int'($urandom_range(0, 65535)));
      end else begin
        span = (eff > 48 && $urandom_range(0, 1) == 0) ? 48 : eff;
        push_edge(start, $urandom_range(0, span - 1), $urandom_range(0, span - 1), wgt);
        wgt = wgt - int'($urandom_range(0, 200));
        if (wgt < -32768)
          wgt = -32768;
      end
      start = 1'b0;
      made++;
      run_left--;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset count (full forest): extreme endpoints and weights, a self loop, a triangle,
    // joining two trees, alternating bit patterns, and a start that breaks old links.
    push_edge(1'b1, 0, 1023, 32767);
    push_edge(1'b0, 1023, 0, 32766);
    push_edge(1'b0, 5, 5, 32000);
    push_edge(1'b0, 1, 2, 100);
    push_edge(1'b0, 2, 3, 99);
    push_edge(1'b0, 3, 1, 98);
    push_edge(1'b0, 0, 3, 97);
    push_edge(1'b0, 1023, 2, 96);
    push_edge(1'b0, 682, 341, -1);
    push_edge(1'b0, 341, 682, -32768);
    push_edge(1'b1, 1023, 0, -32768);

    // Small graph: endpoints at and past the count, and a start on an out-of-range edge.
    write_vertex_count(8);
    push_edge(1'b0, 7, 0, 500);
    push_edge(1'b0, 8, 0, 400);
    push_edge(1'b0, 0, 8, 300);
    push_edge(1'b0, 1023, 1023, 200);
    push_edge(1'b1, 9, 1, 100);
    push_edge(1'b0, 7, 0, 0);

    // A zero count flags every edge.
    write_vertex_count(0);
    push_edge(1'b0, 0, 0, 1);
    push_edge(1'b1, 0, 1, 0);

    write_vertex_count(1);
    push_edge(1'b0, 0, 0, 7);
    push_edge(1'b0, 0, 1, 6);

    // Above the forest size the count is capped.
    write_vertex_count(2047);
    push_edge(1'b1, 1023, 511, 1000);

    // Lowering the count without a start keeps the earlier links.
    write_vertex_count(1024);
    push_edge(1'b1, 3, 12, 50);
    push_edge(1'b0, 12, 9, 40);
    write_vertex_count(16);
    push_edge(1'b0, 9, 3, 30);

    // Random part over a spread of count settings; the last one runs with no idling.
    write_vertex_count(1024);
    queue_random_edges(1024, 130);
    write_vertex_count(64);
    queue_random_edges(64, 130);
    write_vertex_count(16);
    queue_random_edges(16, 120);
    write_vertex_count(2047);
    queue_random_edges(2047, 130);
    write_vertex_count(1025);
    queue_random_edges(1025, 110);
    write_vertex_count(8);
    queue_random_edges(8, 110);
    write_vertex_count(2);
    queue_random_edges(2, 80);
    write_vertex_count(1);
    queue_random_edges(1, 60);
    write_vertex_count(0);
    queue_random_edges(0, 60);
    write_vertex_count(32);
    queue_random_edges(32, 130);
    begin
      int unsigned pick;
      pick = $urandom_range(1, 1024);
      write_vertex_count(pick);
      queue_random_edges(pick, 130);
      pick = $urandom_range(0, 2047);
      write_vertex_count(pick);
      queue_random_edges(pick, 120);
    end
    write_vertex_count(48);
    queue_random_edges(48, 100);
    drain_edges();
    calm = 1'b1;
    write_vertex_count(1024);
    queue_random_edges(1024, 120);

    drain_edges();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

endmodule
